// File: sv/pcr_pkg.sv
// Shared types and constants for the piecewise color ramp.
`default_nettype none

package pcr_pkg;

  localparam int unsigned COLOR_REGS = 4;
  localparam int unsigned WIDTH_REGS = 2;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned TOTAL_W    = 18;
  localparam int unsigned PROD_W     = 33;
  localparam int unsigned QUO_W      = 16;
  localparam int unsigned ADDR_W     = 5;

  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [2:0] {
    REG_USED_COLORS  = 3'd0,
    REG_COLOR_0      = 3'd1,
    REG_COLOR_1      = 3'd2,
    REG_COLOR_2      = 3'd3,
    REG_COLOR_3      = 3'd4,
    REG_SPAN_WIDTH_0 = 3'd5,
    REG_SPAN_WIDTH_1 = 3'd6
  } reg_index_t;

  // Request as it walks the span cells.
  typedef struct packed {
    logic [FRAC_W-1:0]  v;
    logic [TOTAL_W-1:0] total;
    logic               found;
    logic [1:0]         hit;
    logic [COLOR_W-1:0] c_base;
    logic [COLOR_W-1:0] diff;
    logic               neg;
    logic [FRAC_W-1:0]  num;
    logic [FRAC_W-1:0]  w;
  } span_bus_t;

  // Request as it walks the divider cells.
  typedef struct packed {
    logic [PROD_W-1:0]  rem;
    logic [FRAC_W-1:0]  dvs;
    logic [QUO_W-1:0]   quo;
    logic [COLOR_W-1:0] c_base;
    logic               neg;
    logic [1:0]         hit;
  } div_bus_t;

endpackage

`default_nettype wire

// File: sv/pcr_span_cell.sv
// One span of the ramp: checks whether the sample falls in it and picks its colors.
`default_nettype none

module pcr_span_cell import pcr_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ld,
  input  logic               prev_vld,
  input  span_bus_t          prev_bus,
  input  logic [2:0]         n_colors,
  input  logic [FRAC_W-1:0]  width_reg,
  input  logic [COLOR_W-1:0] color_lo,
  input  logic [COLOR_W-1:0] color_hi,
  output logic               vld,
  output span_bus_t          bus
);

  localparam logic [1:0] HIT_CODE = INDEX[1:0];
  localparam logic [2:0] LAST_N   = 3'(INDEX + 2);

  logic               last;
  logic [FRAC_W-1:0]  w;
  logic [TOTAL_W:0]   reach;
  logic               hit_now;
  logic [TOTAL_W-1:0] offset;
  logic [FRAC_W-1:0]  num;
  span_bus_t          bus_next;

  always_comb begin
    last = (n_colors == LAST_N);
    // The last span takes whatever is left of the unit range.
    if (last) begin
      if (prev_bus.total < TOTAL_W'(ONE_Q16)) begin
        w = FRAC_W'(TOTAL_W'(ONE_Q16) - prev_bus.total);
      end else begin
        w = '0;
      end
    end else if (width_reg > ONE_Q16) begin
      w = ONE_Q16;
    end else begin
      w = width_reg;
    end

    reach   = {1'b0, prev_bus.total} + (TOTAL_W+1)'(w);
    hit_now = !prev_bus.found && (last || ((TOTAL_W+1)'(prev_bus.v) <= reach));

    offset = TOTAL_W'(prev_bus.v) - prev_bus.total;
    if (TOTAL_W'(prev_bus.v) > prev_bus.total) begin
      num = (offset > TOTAL_W'(w)) ? w : offset[FRAC_W-1:0];
    end else begin
      num = '0;
    end

    bus_next       = prev_bus;
    bus_next.total = prev_bus.total + TOTAL_W'(w);
    if (hit_now) begin
      bus_next.found  = 1'b1;
      bus_next.hit    = HIT_CODE;
      bus_next.c_base = color_lo;
      bus_next.neg    = (color_hi < color_lo);
      bus_next.diff   = (color_hi < color_lo) ? (color_lo - color_hi) :
                                                (color_hi - color_lo);
      bus_next.num    = num;
      bus_next.w      = w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ld) begin
      vld <= prev_vld;
    end
    if (ld) begin
      bus <= bus_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/pcr_div_cell.sv
// One quotient bit of the restoring divider that scales the color step.
`default_nettype none

module pcr_div_cell import pcr_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     ld,
  input  logic     prev_vld,
  input  div_bus_t prev_bus,
  output logic     vld,
  output div_bus_t bus
);

  logic [PROD_W-1:0] shifted;
  logic              take;
  div_bus_t          bus_next;

  always_comb begin
    shifted = PROD_W'(prev_bus.dvs) << BIT;
    // A zero divisor only comes with a zero dividend; the quotient must stay zero.
    take     = (prev_bus.dvs != '0) && (prev_bus.rem >= shifted);
    bus_next = prev_bus;
    if (take) begin
      bus_next.rem      = prev_bus.rem - shifted;
      bus_next.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ld) begin
      vld <= prev_vld;
    end
    if (ld) begin
      bus <= bus_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/piecewise_color_ramp.sv
// Pipeline: one clamp stage, one span cell per span, a multiply stage, sixteen divider
// cells and the output register. Throughput is one request per cycle while result_ready
// is high; every stage advances on its own, so bubbles close up behind a stalled result.
// Synchronous reset empties the pipeline and returns the configuration registers to defaults.
`default_nettype none

module piecewise_color_ramp import pcr_pkg::*; #(
  parameter int unsigned MAX_COLORS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  logic signed [31:0] sample_value,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [15:0]        mapped_color,
  output logic [1:0]         span_hit,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned EFF_COLORS = (MAX_COLORS < COLOR_REGS) ? MAX_COLORS : COLOR_REGS;
  localparam int unsigned NUM_SPANS  = EFF_COLORS - 1;
  localparam logic [2:0]  MAX_N      = 3'(EFF_COLORS);

  // Configuration registers.
  logic [2:0]         used_colors;
  logic [COLOR_W-1:0] color [COLOR_REGS];
  logic [FRAC_W-1:0]  span_width [WIDTH_REGS];
  logic [2:0]         n_colors;
  reg_index_t         reg_idx;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = reg_index_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_colors   <= 3'd2;
      color[0]      <= 16'h0000;
      color[1]      <= 16'hFF00;
      color[2]      <= 16'h0000;
      color[3]      <= 16'h0000;
      span_width[0] <= 17'h08000;
      span_width[1] <= 17'h08000;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_USED_COLORS:  used_colors   <= pwdata[2:0];
        REG_COLOR_0:      color[0]      <= pwdata[15:0];
        REG_COLOR_1:      color[1]      <= pwdata[15:0];
        REG_COLOR_2:      color[2]      <= pwdata[15:0];
        REG_COLOR_3:      color[3]      <= pwdata[15:0];
        REG_SPAN_WIDTH_0: span_width[0] <= pwdata[16:0];
        REG_SPAN_WIDTH_1: span_width[1] <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_USED_COLORS:  prdata = {29'b0, used_colors};
      REG_COLOR_0:      prdata = {16'b0, color[0]};
      REG_COLOR_1:      prdata = {16'b0, color[1]};
      REG_COLOR_2:      prdata = {16'b0, color[2]};
      REG_COLOR_3:      prdata = {16'b0, color[3]};
      REG_SPAN_WIDTH_0: prdata = {15'b0, span_width[0]};
      REG_SPAN_WIDTH_1: prdata = {15'b0, span_width[1]};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (used_colors == 3'd0) begin
      n_colors = 3'd1;
    end else if (used_colors > MAX_N) begin
      n_colors = MAX_N;
    end else begin
      n_colors = used_colors;
    end
  end

  // Pipeline control: each stage loads when it is empty or its successor loads.
  logic                 prep_vld;
  span_bus_t            prep_bus;
  logic                 ld_prep;
  logic [NUM_SPANS-1:0] svld;
  logic [NUM_SPANS-1:0] ld_span;
  span_bus_t            sbus [NUM_SPANS];
  logic                 mul_vld;
  div_bus_t             mul_bus;
  logic                 ld_mul;
  logic [QUO_W-1:0]     dvld;
  logic [QUO_W-1:0]     ld_div;
  div_bus_t             dbus [QUO_W];
  logic                 ld_out;

  assign ld_out       = !result_valid || result_ready;
  assign ld_mul       = !mul_vld || ld_div[0];
  assign ld_prep      = !prep_vld || ld_span[0];
  assign sample_ready = ld_prep;

  // Clamp stage. With a single color the clamped sample, shifted right by eight bits, is the result.
  span_bus_t         prep_next;
  logic [FRAC_W-1:0] clamped;

  always_comb begin
    if (sample_value[31]) begin
      clamped = '0;
    end else if (sample_value > 32'sh0001_0000) begin
      clamped = ONE_Q16;
    end else begin
      clamped = sample_value[FRAC_W-1:0];
    end
    prep_next        = '0;
    prep_next.v      = clamped;
    prep_next.found  = (n_colors < 3'd2);
    prep_next.c_base = (n_colors < 3'd2) ? COLOR_W'(clamped >> 8) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_vld <= 1'b0;
    end else if (ld_prep) begin
      prep_vld <= sample_valid;
    end
    if (ld_prep) begin
      prep_bus <= prep_next;
    end
  end

  // Span cells.
  for (genvar i = 0; i < NUM_SPANS; i++) begin : g_span
    logic [FRAC_W-1:0] wreg;
    logic              vin;
    span_bus_t         bin;

    if (i < WIDTH_REGS) begin : g_w
      assign wreg = span_width[i];
    end else begin : g_nw
      assign wreg = '0;
    end

    if (i == 0) begin : g_first
      assign vin = prep_vld;
      assign bin = prep_bus;
    end else begin : g_mid
      assign vin = svld[i-1];
      assign bin = sbus[i-1];
    end

    if (i == NUM_SPANS - 1) begin : g_ld_last
      assign ld_span[i] = !svld[i] || ld_mul;
    end else begin : g_ld_mid
      assign ld_span[i] = !svld[i] || ld_span[i+1];
    end

    pcr_span_cell #(
      .INDEX(i)
    ) u_span (
      .clk      (clk),
      .rst      (rst),
      .ld       (ld_span[i]),
      .prev_vld (vin),
      .prev_bus (bin),
      .n_colors (n_colors),
      .width_reg(wreg),
      .color_lo (color[i]),
      .color_hi (color[i+1]),
      .vld      (svld[i]),
      .bus      (sbus[i])
    );
  end

  // Multiply stage: color difference times offset into the span.
  div_bus_t  mul_next;
  span_bus_t stail;

  assign stail = sbus[NUM_SPANS-1];

  always_comb begin
    mul_next        = '0;
    mul_next.rem    = {17'b0, stail.diff} * {16'b0, stail.num};
    mul_next.dvs    = stail.w;
    mul_next.c_base = stail.c_base;
    mul_next.neg    = stail.neg;
    mul_next.hit    = stail.hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
    end else if (ld_mul) begin
      mul_vld <= svld[NUM_SPANS-1];
    end
    if (ld_mul) begin
      mul_bus <= mul_next;
    end
  end

  // Divider cells, most significant quotient bit first.
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic     vin;
    div_bus_t bin;

    if (k == 0) begin : g_first
      assign vin = mul_vld;
      assign bin = mul_bus;
    end else begin : g_mid
      assign vin = dvld[k-1];
      assign bin = dbus[k-1];
    end

    if (k == QUO_W - 1) begin : g_ld_last
      assign ld_div[k] = !dvld[k] || ld_out;
    end else begin : g_ld_mid
      assign ld_div[k] = !dvld[k] || ld_div[k+1];
    end

    pcr_div_cell #(
      .BIT(QUO_W - 1 - k)
    ) u_div (
      .clk     (clk),
      .rst     (rst),
      .ld      (ld_div[k]),
      .prev_vld(vin),
      .prev_bus(bin),
      .vld     (dvld[k]),
      .bus     (dbus[k])
    );
  end

  // Output register.
  div_bus_t dtail;

  assign dtail = dbus[QUO_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ld_out) begin
      result_valid <= dvld[QUO_W-1];
    end
    if (ld_out) begin
      mapped_color <= dtail.neg ? (dtail.c_base - dtail.quo) : (dtail.c_base + dtail.quo);
      span_hit     <= dtail.hit;
    end
  end

  // An accepted result always frees the whole pipeline to take a new request.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    result_ready |-> sample_ready)
    else $error("request refused while the result side was draining");

  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(span_hit) < NUM_SPANS))
    else $error("span index beyond the configured spans");

  // Requests in flight change only by what the two handshakes move.
  a_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |->
      ($countones({prep_vld, svld, mul_vld, dvld, result_valid}) ==
       $past($countones({prep_vld, svld, mul_vld, dvld, result_valid}))
       + $past(32'(sample_valid && sample_ready))
       - $past(32'(result_valid && result_ready))))
    else $error("request lost or duplicated in the pipeline");

  a_one_color: assert property (@(posedge clk) disable iff (rst)
    (prep_vld && prep_bus.found) |-> (prep_bus.c_base <= 16'h0100))
    else $error("single color result outside the clamped range");

endmodule

`default_nettype wire

// File: tb/piecewise_color_ramp_tb.sv
// Self-checking testbench for the piecewise color ramp: directed corners, then random ramps.
module piecewise_color_ramp_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcr_pkg::*;

  localparam int unsigned RAMP_COLORS = 4;
  localparam int unsigned ONE = 65536;
  localparam int unsigned DRAIN_CYCLES = 30;

  typedef struct {
    logic signed [31:0] sample;
    logic [15:0]        color;
    logic [1:0]         span;
  } ramp_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               sample_valid = 1'b0;
  logic               sample_ready;
  logic signed [31:0] sample_value = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic [15:0]        mapped_color;
  logic [1:0]         span_hit;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Local copy of the ramp registers, starting at their reset values.
  logic [2:0]  cfg_used = 3'd2;
  logic [15:0] cfg_color [RAMP_COLORS] = '{16'h0000, 16'hFF00, 16'h0000, 16'h0000};
  logic [16:0] cfg_width [WIDTH_REGS] = '{17'h08000, 17'h08000};

  logic signed [31:0] pending_samples [$];
  ramp_result_t       expected_colors [$];
  int unsigned        mismatches = 0;
  bit                 steady = 1'b0;
  int unsigned        burst_left = 0;
  int unsigned        gap_left = 0;
  logic [15:0]        stall_bits = 16'hFFFF;
  int unsigned        pattern_age = 0;

  piecewise_color_ramp uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_value (sample_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .mapped_color (mapped_color),
    .span_hit     (span_hit),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk = ~clk;

  function automatic ramp_result_t predict_color(input logic signed [31:0] sample);
    ramp_result_t    r;
    int unsigned     v;
    int unsigned     n;
    int unsigned     total;
    int unsigned     w;
    int unsigned     num;
    int unsigned     c_lo;
    int unsigned     c_hi;
    longint unsigned step;
    bit              last;
    r.sample = sample;
    r.color = '0;
    r.span = '0;
    if (sample < 0) v = 0;
    else if (sample > 32'sh10000) v = ONE;
    else v = sample;
    n = cfg_used;
    if (n < 1) n = 1;
    if (n > RAMP_COLORS) n = RAMP_COLORS;
    if (n < 2) begin
      r.color = 16'(v >> 8);
      return r;
    end
    total = 0;
    for (int unsigned i = 0; i + 1 < n; i++) begin
      last = (i + 2 == n);
      if (last) begin
        w = (total < ONE) ? ONE - total : 0;
      end else begin
        w = (i < WIDTH_REGS) ? cfg_width[i] : 0;
        if (w > ONE) w = ONE;
      end
      if (last || v <= total + w) begin
        num = (v > total) ? v - total : 0;
        if (num > w) num = w;
        c_lo = cfg_color[i];
        c_hi = cfg_color[i + 1];
        // The quotient is truncated toward the span's first color.
        if (w == 0 || num == 0) begin
          r.color = 16'(c_lo);
        end else if (c_hi >= c_lo) begin
          step = (longint'(c_hi - c_lo) * num) / w;
          r.color = 16'(c_lo + step);
        end else begin
          step = (longint'(c_lo - c_hi) * num) / w;
          r.color = 16'(c_lo - step);
        end
        r.span = 2'(i);
        break;
      end
      total += w;
    end
    return r;
  endfunction

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_USED_COLORS:  cfg_used = value[2:0];
      REG_COLOR_0:      cfg_color[0] = value[15:0];
      REG_COLOR_1:      cfg_color[1] = value[15:0];
      REG_COLOR_2:      cfg_color[2] = value[15:0];
      REG_COLOR_3:      cfg_color[3] = value[15:0];
      REG_SPAN_WIDTH_0: cfg_width[0] = value[16:0];
      REG_SPAN_WIDTH_1: cfg_width[1] = value[16:0];
      default: ;
    endcase
  endtask

  task automatic program_ramp(input logic [2:0] used, input logic [15:0] c0,
                              input logic [15:0] c1, input logic [15:0] c2,
                              input logic [15:0] c3, input logic [16:0] w0,
                              input logic [16:0] w1);
    write_reg(REG_USED_COLORS, 32'(used));
    write_reg(REG_COLOR_0, 32'(c0));
    write_reg(REG_COLOR_1, 32'(c1));
    write_reg(REG_COLOR_2, 32'(c2));
    write_reg(REG_COLOR_3, 32'(c3));
    write_reg(REG_SPAN_WIDTH_0, 32'(w0));
    write_reg(REG_SPAN_WIDTH_1, 32'(w1));
  endtask

  function automatic logic [15:0] pick_color();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] pick_width();
    case ($urandom_range(0, 7))
      0: return 17'h00000;
      1: return 17'h10000;
      2: return 17'($urandom_range(ONE + 1, 2 * ONE - 1));
      3: return 17'($urandom_range(0, 255));
      default: return 17'($urandom_range(0, ONE));
    endcase
  endfunction

  // Mostly in-range samples, some placed on span boundaries, the rest raw 32-bit noise.
  function automatic logic signed [31:0] pick_sample();
    int unsigned b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 32'($urandom_range(0, ONE));
      6: begin
        b = (cfg_width[0] > ONE) ? ONE : cfg_width[0];
        if ($urandom_range(0, 1)) b += (cfg_width[1] > ONE) ? ONE : cfg_width[1];
        return 32'(b + $urandom_range(0, 2) - 1);
      end
      default: return 32'($urandom);
    endcase
  endfunction

  // Holds off new configuration until every request has drained from the pipeline.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_samples.size() != 0 || sample_valid || expected_colors.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Request driver: bursts of random length separated by random gaps; gaps are skipped while steady is set.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (sample_valid && sample_ready)
        expected_colors.push_back(predict_color(sample_value));
      if (!sample_valid || sample_ready) begin
        if (gap_left > 0 && !steady) begin
          gap_left--;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample_value <= pending_samples.pop_front();
          sample_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with its own randomly reshuffled stall pattern; result_ready stays high while steady is set.
  always @(posedge clk) begin
    ramp_result_t want;
    if (result_valid && result_ready) begin
      if (expected_colors.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: color %h span %0d", mapped_color, span_hit);
        mismatches++;
      end else begin
        want = expected_colors.pop_front();
        if (mapped_color !== want.color || span_hit !== want.span) begin
          if (mismatches < 10)
            $display("mismatch for sample %h: expected color %h span %0d, got color %h span %0d",
                     want.sample, want.color, want.span, mapped_color, span_hit);
          mismatches++;
        end
      end
    end
    if (pattern_age == 0) begin
      pattern_age = 40;
      case ($urandom_range(0, 3))
        0: stall_bits = 16'hFFFF;
        1: stall_bits = 16'($urandom);
        2: stall_bits = 16'($urandom | $urandom);
        default: stall_bits = 16'($urandom & $urandom);
      endcase
    end
    pattern_age--;
    result_ready <= steady ? 1'b1 : stall_bits[0];
    stall_bits = {stall_bits[0], stall_bits[15:1]};
  end

  initial begin
    #5_000_000;
    $display("FAIL piecewise_color_ramp");
    $finish;
  end

  initial begin
    logic signed [31:0] reset_corners [] = '{32'h0, 32'h1, 32'h8000, 32'h8001, 32'hFFFF,
                                             32'h10000, 32'h10001, 32'h7FFFFFFF,
                                             32'h80000000, 32'hFFFFFFFF};
    logic signed [31:0] gray_corners [] = '{32'h0, 32'h80, 32'hFFFF, 32'h10000, 32'h7FFFFFFF};
    logic signed [31:0] wide_corners [] = '{32'h0, 32'h1, 32'h8000, 32'h10000};
    logic signed [31:0] fall_corners [] = '{32'h4000, 32'h4001, 32'h9000, 32'h10000};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: a two-color ramp from black to nearly full scale.
    wait_idle();
    foreach (reset_corners[k]) pending_samples.push_back(reset_corners[k]);

    // A single color means no spans: the clamped sample, shifted right by eight bits, passes through.
    wait_idle();
    program_ramp(3'd1, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 17'h08000, 17'h08000);
    foreach (gray_corners[k]) pending_samples.push_back(gray_corners[k]);

    // A color count of zero behaves as one color.
    wait_idle();
    write_reg(REG_USED_COLORS, 32'd0);
    pending_samples.push_back(32'h8000);
    pending_samples.push_back(32'h10000);

    // Oversized count saturates; a zero-width span and an over-unity width follow.
    wait_idle();
    program_ramp(3'd7, 16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF, 17'h00000, 17'h1FFFF);
    foreach (wide_corners[k]) pending_samples.push_back(wide_corners[k]);

    // Falling and rising colors, with the last span taking the remainder.
    wait_idle();
    program_ramp(3'd3, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 17'h04000, 17'h00000);
    foreach (fall_corners[k]) pending_samples.push_back(fall_corners[k]);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: program_ramp(3'd4, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 17'h1FFFF, 17'h00000);
        1: program_ramp(3'd4, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 17'h05555, 17'h0AAAA);
        default: program_ramp(3'($urandom_range(0, 7)), pick_color(), pick_color(),
                              pick_color(), pick_color(), pick_width(), pick_width());
      endcase
      steady = (p == 3);
      for (int k = 0; k < 50; k++) pending_samples.push_back(pick_sample());
    end

    wait_idle();
    if (mismatches == 0 && expected_colors.size() == 0)
      $display("PASS piecewise_color_ramp");
    else
      $display("FAIL piecewise_color_ramp");
    $finish;
  end

endmodule

// File: filelist.f
sv/pcr_pkg.sv
sv/pcr_span_cell.sv
sv/pcr_div_cell.sv
sv/piecewise_color_ramp.sv
tb/piecewise_color_ramp_tb.sv
